// ----- hdl/hvd_pkg.sv -----
// ----------------------------------------------------------------------------
// hvd_pkg - shared types and constants for the haversine distance pipeline
// Fixed-point formats, CORDIC arctangent table and pipeline geometry.
// ----------------------------------------------------------------------------
package hvd_pkg;

  // angle format of the coordinates: degrees * 2^ANGLE_FRAC_BITS
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_STEPS    = 24;

  localparam int LAT_W = 24;
  localparam int LON_W = 25;
  // a difference of two longitudes needs one bit more
  localparam int ANG_W = 26;

  // one full turn in input units, and the width of an angle reduced to it
  localparam int FULL_TURN = 360 * (2 ** ANGLE_FRAC_BITS);
  localparam int RED_W     = $clog2(FULL_TURN);

  // turns = (r * 2^(32-F) + 180) / 360 is done as ((r * 2^(29-F) + 22) / 45)
  localparam int LO_SHIFT  = 29 - ANGLE_FRAC_BITS;
  localparam int TURN_BIAS = 180 / 8;
  localparam int QUO_W     = RED_W - 5;
  localparam int LO_W      = LO_SHIFT + 6;

  // ceil(2^32 / 45): exact floor quotient for dividends below 2^28
  localparam int           RECIP_W = 27;
  localparam int           RECIP_SH = 32;
  localparam logic [26:0]  RECIP45 = 27'd95443718;

  // CORDIC datapath
  localparam int CW = 34;
  typedef logic signed [CW-1:0] cval_t;
  localparam cval_t CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    cval_t      x;
    cval_t      y;
    cval_t      z;
    logic [1:0] quad;
  } cordic_vec_t;

  // Q30 values
  localparam int ONE_Q30 = 1 << 30;

  // bitwise square root
  localparam int SQRT_BITS = 31;
  localparam int SQRT_STEP_W = $clog2(SQRT_BITS);
  localparam int REM_W     = 61;

  // scaling of the central angle
  localparam logic [31:0] PI30     = 32'd3373259426;
  localparam int          RADIUS_W = 16;
  localparam int          DIST_W   = 28;
  localparam logic [27:0] DIST_MAX = 28'd210828714;
  localparam logic [15:0] RADIUS_RESET = 16'd6371;

  // stream widths
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 32;

  // register stages from input beat to the last multiply
  localparam int PIPE_DEPTH = 5 + CORDIC_STEPS + 5 + SQRT_BITS + CORDIC_STEPS + 4;

  // configuration register index
  typedef enum logic {
    CFG_RADIUS = 1'b0
  } cfg_reg_t;

  // atan(2^-i) in turns scaled by 2^32
  function automatic logic [29:0] step_angle(input logic [5:0] i);
    logic [29:0] a;
    case (i)
      6'd0:  a = 30'd536870912;
      6'd1:  a = 30'd316933406;
      6'd2:  a = 30'd167458907;
      6'd3:  a = 30'd85004756;
      6'd4:  a = 30'd42667331;
      6'd5:  a = 30'd21354465;
      6'd6:  a = 30'd10679838;
      6'd7:  a = 30'd5340245;
      6'd8:  a = 30'd2670163;
      6'd9:  a = 30'd1335087;
      6'd10: a = 30'd667544;
      6'd11: a = 30'd333772;
      6'd12: a = 30'd166886;
      6'd13: a = 30'd83443;
      6'd14: a = 30'd41722;
      6'd15: a = 30'd20861;
      6'd16: a = 30'd10430;
      6'd17: a = 30'd5215;
      6'd18: a = 30'd2608;
      6'd19: a = 30'd1304;
      6'd20: a = 30'd652;
      6'd21: a = 30'd326;
      6'd22: a = 30'd163;
      6'd23: a = 30'd81;
      6'd24: a = 30'd41;
      6'd25: a = 30'd20;
      6'd26: a = 30'd10;
      6'd27: a = 30'd5;
      6'd28: a = 30'd3;
      6'd29: a = 30'd1;
      6'd30: a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

// ----- hdl/haversine_distance.sv -----
// ----------------------------------------------------------------------------
// haversine_distance - great-circle distance of two points, haversine formula
// Cosines by a rotation CORDIC, bitwise square roots and a vectoring CORDIC
// for the central angle, scaled by the programmable sphere radius.
// ----------------------------------------------------------------------------
//   channel  dir   beat contents
//   in_      in    lat1 [23:0], lon1 [48:24], lat2 [72:49], lon2 [97:73]
//   out_     out   distance in 1/1024 km [27:0]
//   cfg_     APB   radius register at byte address 0
//
// One pair is accepted per clock while the pipeline is not held; its result
// passes through the chained CORDIC and square-root cells to the output.
// The whole pipeline advances together; it holds only when the output
// register is full and not taken while a result arrives behind it.
// rst_n is synchronous: it clears the pipeline valid bits and the output
// valid, and sets the radius to 6371.
// ----------------------------------------------------------------------------
module haversine_distance (
  input  logic                               clk,
  input  logic                               rst_n,
  // lat1 [23:0], lon1 [48:24], lat2 [72:49], lon2 [97:73]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [hvd_pkg::IN_TDATA_W-1:0]     in_tdata,
  // great_circle_distance [27:0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [hvd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [2:0]                         cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  localparam int NL  = 4;
  localparam int NS  = hvd_pkg::CORDIC_STEPS;
  localparam int SB  = hvd_pkg::SQRT_BITS;
  localparam int PD  = hvd_pkg::PIPE_DEPTH;
  localparam logic signed [31:0] ONE32 = 32'sd1073741824;
  localparam logic signed [32:0] ONE33 = 33'sd1073741824;
  localparam logic signed [33:0] ONE34 = 34'sd1073741824;

  logic                          en;
  logic [PD-1:0]                 vld_r;
  logic [hvd_pkg::RADIUS_W-1:0]  radius_r;
  logic                          cfg_wr;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= hvd_pkg::RADIUS_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == hvd_pkg::CFG_RADIUS)) begin
      radius_r <= cfg_pwdata[hvd_pkg::RADIUS_W-1:0];
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      hvd_pkg::CFG_RADIUS: cfg_prdata = 32'(radius_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  logic                          out_valid_r;
  logic [hvd_pkg::DIST_W-1:0]    dist_r, dist_nxt;

  assign en        = !(out_valid_r && !out_tready && vld_r[PD-1]);
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PD-2:0], in_tvalid};
    end
  end

  // ---------------- unpack and angle conversion ----------------
  logic signed [hvd_pkg::LAT_W-1:0] lat1, lat2;
  logic signed [hvd_pkg::LON_W-1:0] lon1, lon2;
  logic signed [hvd_pkg::ANG_W-1:0] ang [NL];
  logic [1:0]                       quad [NL];
  logic signed [31:0]               z0 [NL];

  assign lat1 = in_tdata[23:0];
  assign lon1 = in_tdata[48:24];
  assign lat2 = in_tdata[72:49];
  assign lon2 = in_tdata[97:73];

  // lanes: 0 = dlat, 1 = dlon, 2 = lat1, 3 = lat2
  assign ang[0] = hvd_pkg::ANG_W'(lat2) - hvd_pkg::ANG_W'(lat1);
  assign ang[1] = hvd_pkg::ANG_W'(lon2) - hvd_pkg::ANG_W'(lon1);
  assign ang[2] = hvd_pkg::ANG_W'(lat1);
  assign ang[3] = hvd_pkg::ANG_W'(lat2);

  // ---------------- cosine CORDIC rows ----------------
  hvd_pkg::cordic_vec_t cos_pipe [NL][NS+1];

  genvar l, j;
  generate
    for (l = 0; l < NL; l++) begin : g_lane
      hvd_turns u_turns (
        .clk     (clk),
        .en      (en),
        .angle_i (ang[l]),
        .quad_r  (quad[l]),
        .z_r     (z0[l])
      );

      assign cos_pipe[l][0].x    = hvd_pkg::CORDIC_GAIN;
      assign cos_pipe[l][0].y    = '0;
      assign cos_pipe[l][0].z    = hvd_pkg::CW'(z0[l]);
      assign cos_pipe[l][0].quad = quad[l];

      for (j = 0; j < NS; j++) begin : g_cell
        hvd_cordic_cell u_cell (
          .clk       (clk),
          .en        (en),
          .step      (6'(j)),
          .vectoring (1'b0),
          .vec_i     (cos_pipe[l][j]),
          .vec_r     (cos_pipe[l][j+1])
        );
      end
    end
  endgenerate

  // ---------------- quadrant select and clamp ----------------
  logic signed [31:0] cos_r [NL];
  logic signed [31:0] cos_nxt [NL];

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      hvd_pkg::cval_t c;
      case (cos_pipe[k][NS].quad)
        2'd0:    c = cos_pipe[k][NS].x;
        2'd1:    c = -cos_pipe[k][NS].y;
        2'd2:    c = -cos_pipe[k][NS].x;
        default: c = cos_pipe[k][NS].y;
      endcase
      if (c > ONE34) begin
        c = ONE34;
      end else if (c < -ONE34) begin
        c = -ONE34;
      end
      cos_nxt[k] = 32'(c);
    end
  end

  // ---------------- haversine terms ----------------
  logic signed [32:0] dif_lat, dif_lon;
  logic [30:0]        hlat_nxt, hlon_nxt, hlat_r, hlon_r, hlat_e_r, hlon_e_r, hlat_f_r;
  logic signed [63:0] cc_nxt, cc_r, pcsum, tp_nxt, tp_r, tsum;
  logic signed [31:0] pc_nxt, pc_r, hlon_s;
  logic signed [33:0] term, hsum;
  logic [30:0]        h_nxt, h_r;

  // (1 - cos x) / 2 and the product of the latitude cosines
  assign dif_lat  = ONE33 - 33'(cos_r[0]);
  assign dif_lon  = ONE33 - 33'(cos_r[1]);
  assign hlat_nxt = dif_lat[31:1];
  assign hlon_nxt = dif_lon[31:1];
  assign cc_nxt   = 64'(cos_r[2]) * 64'(cos_r[3]);

  // round to Q30
  assign pcsum  = cc_r + 64'sd536870912;
  assign pc_nxt = 32'(pcsum >>> 30);

  assign hlon_s = {1'b0, hlon_e_r};
  assign tp_nxt = 64'(pc_r) * 64'(hlon_s);

  // h, clamped to [0, 1]
  always_comb begin
    tsum = tp_r + 64'sd536870912;
    term = 34'(tsum >>> 30);
    hsum = 34'(hlat_f_r) + term;
    if (hsum < 0) begin
      h_nxt = '0;
    end else if (hsum > ONE34) begin
      h_nxt = 31'(ONE34);
    end else begin
      h_nxt = hsum[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r    <= cos_nxt;
      hlat_r   <= hlat_nxt;
      hlon_r   <= hlon_nxt;
      cc_r     <= cc_nxt;
      pc_r     <= pc_nxt;
      hlat_e_r <= hlat_r;
      hlon_e_r <= hlon_r;
      tp_r     <= tp_nxt;
      hlat_f_r <= hlat_e_r;
      h_r      <= h_nxt;
    end
  end

  // ---------------- square roots of h and 1 - h ----------------
  logic [hvd_pkg::REM_W-1:0] sq_rem  [2][SB+1];
  logic [SB-1:0]             sq_root [2][SB+1];

  assign sq_rem[0][0]  = {h_r, 30'b0};
  assign sq_rem[1][0]  = {31'(ONE32) - h_r, 30'b0};
  assign sq_root[0][0] = '0;
  assign sq_root[1][0] = '0;

  generate
    for (l = 0; l < 2; l++) begin : g_sq_lane
      for (j = 0; j < SB; j++) begin : g_sq_cell
        hvd_sqrt_cell u_cell (
          .clk    (clk),
          .en     (en),
          .step   (hvd_pkg::SQRT_STEP_W'(SB - 1 - j)),
          .rem_i  (sq_rem[l][j]),
          .root_i (sq_root[l][j]),
          .rem_r  (sq_rem[l][j+1]),
          .root_r (sq_root[l][j+1])
        );
      end
    end
  endgenerate

  // ---------------- vectoring CORDIC: atan2(sqrt h, sqrt(1-h)) ----------------
  hvd_pkg::cordic_vec_t vec_pipe [NS+1];

  assign vec_pipe[0].x    = hvd_pkg::CW'(sq_root[1][SB]);
  assign vec_pipe[0].y    = hvd_pkg::CW'(sq_root[0][SB]);
  assign vec_pipe[0].z    = '0;
  assign vec_pipe[0].quad = '0;

  generate
    for (j = 0; j < NS; j++) begin : g_vec_cell
      hvd_cordic_cell u_cell (
        .clk       (clk),
        .en        (en),
        .step      (6'(j)),
        .vectoring (1'b1),
        .vec_i     (vec_pipe[j]),
        .vec_r     (vec_pipe[j+1])
      );
    end
  endgenerate

  // ---------------- angle clamp and scaling ----------------
  hvd_pkg::cval_t zv;
  logic [30:0]    zc_nxt, zc_r;
  logic [62:0]    ap_nxt, ap_r, apsum;
  logic [31:0]    qv_nxt, qv_r;
  logic [47:0]    rp_nxt, rp_r, rpsum;

  always_comb begin
    zv = vec_pipe[NS].z;
    if (zv < 0) begin
      zc_nxt = '0;
    end else if (zv > ONE34) begin
      zc_nxt = 31'(ONE34);
    end else begin
      zc_nxt = zv[30:0];
    end
  end

  assign ap_nxt = 63'(zc_r) * 63'(hvd_pkg::PI30);
  assign apsum  = ap_r + 63'(64'd536870912);
  assign qv_nxt = apsum[61:30];
  assign rp_nxt = 48'(radius_r) * 48'(qv_r);
  assign rpsum  = rp_r + 48'd524288;

  // round to 1/1024 km and saturate
  always_comb begin
    if (rpsum[47:20] > hvd_pkg::DIST_MAX) begin
      dist_nxt = hvd_pkg::DIST_MAX;
    end else begin
      dist_nxt = rpsum[47:20];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zc_r <= zc_nxt;
      ap_r <= ap_nxt;
      qv_r <= qv_nxt;
      rp_r <= rp_nxt;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && vld_r[PD-1]) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld_r[PD-1]) begin
      dist_r <= dist_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = hvd_pkg::OUT_TDATA_W'(dist_r);

endmodule

// ----- hdl/hvd_turns.sv -----
// ----------------------------------------------------------------------------
// hvd_turns - angle to binary-angle conversion
// Wraps a signed angle to one turn, scales it to 2^32 per turn with rounding,
// and splits it into a quadrant and a residual for the rotation CORDIC.
// ----------------------------------------------------------------------------
module hvd_turns (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [hvd_pkg::ANG_W-1:0]  angle_i,
  output logic [1:0]                        quad_r,
  output logic signed [31:0]                z_r
);

  localparam int SW = hvd_pkg::ANG_W + 1;
  localparam logic signed [SW-1:0] FULL_S = SW'(hvd_pkg::FULL_TURN);
  localparam int P1_W = hvd_pkg::RED_W + hvd_pkg::RECIP_W;
  localparam int P2_W = hvd_pkg::LO_W + hvd_pkg::RECIP_W;

  logic signed [SW-1:0]           s0, s1, s2;
  logic [hvd_pkg::RED_W-1:0]      red_nxt, red_r, red2_r;
  logic [P1_W-1:0]                prod1;
  logic [hvd_pkg::QUO_W-1:0]      quo_nxt, quo_r, quo3_r;
  logic [hvd_pkg::RED_W-1:0]      m45;
  logic [5:0]                     rem_nxt, rem_r;
  logic [hvd_pkg::LO_W-1:0]       xnum;
  logic [P2_W-1:0]                prod2;
  logic [31:0]                    t_nxt, t_r, ts, d;
  logic [1:0]                     quad_nxt;

  // wrap into [0, full turn)
  always_comb begin
    s0 = SW'(angle_i);
    if (s0 < 0) begin
      s1 = s0 + FULL_S;
    end else if (s0 >= FULL_S) begin
      s1 = s0 - FULL_S;
    end else begin
      s1 = s0;
    end
    s2 = (s1 < 0) ? s1 + FULL_S : s1;
    red_nxt = s2[hvd_pkg::RED_W-1:0];
  end

  // coarse quotient by 45 via reciprocal
  assign prod1   = P1_W'(red_r) * P1_W'(hvd_pkg::RECIP45);
  assign quo_nxt = prod1[hvd_pkg::RECIP_SH +: hvd_pkg::QUO_W];

  // remainder by 45, below 45
  assign m45 = hvd_pkg::RED_W'({quo_r, 5'b0}) + hvd_pkg::RED_W'({quo_r, 3'b0})
             + hvd_pkg::RED_W'({quo_r, 2'b0}) + hvd_pkg::RED_W'(quo_r);
  assign rem_nxt = 6'(red2_r - m45);

  // low part of the binary angle from the remainder
  assign xnum  = {rem_r, hvd_pkg::LO_SHIFT'(0)} + hvd_pkg::LO_W'(hvd_pkg::TURN_BIAS);
  assign prod2 = P2_W'(xnum) * P2_W'(hvd_pkg::RECIP45);
  assign t_nxt = 32'({quo3_r, hvd_pkg::LO_SHIFT'(0)})
               + 32'(prod2[P2_W-1:hvd_pkg::RECIP_SH]);

  // quadrant around each axis, residual within +-45 degrees
  assign ts       = t_r + 32'h2000_0000;
  assign quad_nxt = ts[31:30];
  assign d        = t_r - {quad_nxt, 30'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      red_r  <= red_nxt;
      red2_r <= red_r;
      quo_r  <= quo_nxt;
      quo3_r <= quo_r;
      rem_r  <= rem_nxt;
      t_r    <= t_nxt;
      quad_r <= quad_nxt;
      z_r    <= signed'(d);
    end
  end

endmodule

// ----- hdl/hvd_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// hvd_cordic_cell - one CORDIC micro-rotation
// Rotation mode steers by the sign of z, vectoring mode by the sign of y.
// ----------------------------------------------------------------------------
module hvd_cordic_cell (
  input  logic                  clk,
  input  logic                  en,
  input  logic [5:0]            step,
  input  logic                  vectoring,
  input  hvd_pkg::cordic_vec_t  vec_i,
  output hvd_pkg::cordic_vec_t  vec_r
);

  hvd_pkg::cval_t       xi, yi, zi, dx, dy, ang;
  logic                 sub;
  hvd_pkg::cordic_vec_t vec_nxt;

  always_comb begin
    xi  = vec_i.x;
    yi  = vec_i.y;
    zi  = vec_i.z;
    dx  = yi >>> step;
    dy  = xi >>> step;
    ang = hvd_pkg::CW'(hvd_pkg::step_angle(step));
    // both modes share one pair of add/subtract directions
    sub = vectoring ? (yi <= 0) : (zi >= 0);
    vec_nxt.quad = vec_i.quad;
    if (sub) begin
      vec_nxt.x = xi - dx;
      vec_nxt.y = yi + dy;
      vec_nxt.z = zi - ang;
    end else begin
      vec_nxt.x = xi + dx;
      vec_nxt.y = yi - dy;
      vec_nxt.z = zi + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

endmodule

// ----- hdl/hvd_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// hvd_sqrt_cell - one result bit of a restoring integer square root
// Holds the partial root and the remainder n - root^2.
// ----------------------------------------------------------------------------
module hvd_sqrt_cell (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic [hvd_pkg::SQRT_STEP_W-1:0]        step,
  input  logic [hvd_pkg::REM_W-1:0]              rem_i,
  input  logic [hvd_pkg::SQRT_BITS-1:0]          root_i,
  output logic [hvd_pkg::REM_W-1:0]              rem_r,
  output logic [hvd_pkg::SQRT_BITS-1:0]          root_r
);

  localparam int TW = hvd_pkg::REM_W + 2;

  logic [TW-1:0]                 trial;
  logic                          ge;
  logic [hvd_pkg::REM_W-1:0]     rem_nxt;
  logic [hvd_pkg::SQRT_BITS-1:0] root_nxt;

  // (root + 2^k)^2 - root^2 = root * 2^(k+1) + 2^(2k)
  always_comb begin
    trial    = (TW'(root_i) << (step + 1)) | (TW'(1) << (2 * step));
    ge       = TW'(rem_i) >= trial;
    rem_nxt  = ge ? hvd_pkg::REM_W'(TW'(rem_i) - trial) : rem_i;
    root_nxt = ge ? (root_i | (hvd_pkg::SQRT_BITS'(1) << step)) : root_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

endmodule

// ----- hdl/hvd_checker.sv -----
// ----------------------------------------------------------------------------
// hvd_checker - port-level checks for haversine_distance
// Watches the stream and register ports; attached to the top level by bind.
// ----------------------------------------------------------------------------
module hvd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [hvd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                             cfg_psel,
  input logic                             cfg_penable,
  input logic                             cfg_pwrite,
  input logic [2:0]                       cfg_paddr,
  input logic [31:0]                      cfg_pwdata,
  input logic [31:0]                      cfg_prdata
);

  // a result never exceeds the saturation limit and pads with zeros
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata <= hvd_pkg::OUT_TDATA_W'(hvd_pkg::DIST_MAX)))
    else $error("distance beat above saturation limit");

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // a radius write reads back on the next cycle
  a_radius_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2])
    |=> (cfg_prdata == {16'b0, $past(cfg_pwdata[15:0])}))
    else $error("radius register readback mismatch");

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("output beat dropped or changed under stall");

endmodule

bind haversine_distance hvd_checker u_hvd_checker (.*);
